@@ sv/cns_pkg.sv @@
// Shared types, codes and helpers of the numeric constant scanner.
`default_nettype none
package cns_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ZERO,
        PH_BODY,
        PH_SUFFIX
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // token kinds
    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_FLOAT = 2'd2;

    // type codes
    localparam logic [2:0] TY_INT    = 3'd0;
    localparam logic [2:0] TY_UINT   = 3'd1;
    localparam logic [2:0] TY_LONG   = 3'd2;
    localparam logic [2:0] TY_ULONG  = 3'd3;
    localparam logic [2:0] TY_FLOAT  = 3'd4;
    localparam logic [2:0] TY_DOUBLE = 3'd5;
    localparam logic [2:0] TY_LDBL   = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_FLT_SUFX  = 2'd2;
    localparam logic [1:0] ERR_INT_SUFX  = 2'd3;

    // promotion codes
    localparam logic [1:0] PROMO_NONE  = 2'd0;
    localparam logic [1:0] PROMO_LONG  = 2'd1;
    localparam logic [1:0] PROMO_ULONG = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SI_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UI_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SL_MASK = 2'd2;

    localparam logic [31:0] SIMASK = 32'hFFFF_8000;
    localparam logic [31:0] UIMASK = 32'hFFFF_0000;
    localparam logic [31:0] SLMASK = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] si_mask;
        logic [31:0] ui_mask;
        logic [31:0] sl_mask;
    } masks_t;

    // scan state apart from the character count
    typedef struct packed {
        phase_t      phase;
        base_t       base;
        logic        dot_seen;
        logic        exp_seen;
        logic        sign_ok;
        logic [31:0] acc;
        logic        too_long;
        logic [1:0]  long_sfx;
        logic [1:0]  uns_sfx;
        logic [1:0]  flt_sfx;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase:    PH_IDLE,
        base:     BASE_DEC,
        dot_seen: 1'b0,
        exp_seen: 1'b0,
        sign_ok:  1'b0,
        acc:      32'd0,
        too_long: 1'b0,
        long_sfx: 2'd0,
        uns_sfx:  2'd0,
        flt_sfx:  2'd0
    };

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [2:0]  type_code;
        logic [31:0] value;
        logic [1:0]  error_code;
        logic [1:0]  promotion;
        logic        char_consumed;
    } result_t;

    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        return (v < 2'd2) ? v + 2'd1 : 2'd2;
    endfunction

endpackage
`default_nettype wire

@@ sv/c_numeric_constant_scanner_top.sv @@
// Top level of the C numeric constant scanner: request register, scan state, result register.
//
//   channel | ports                                              | direction
//   s_      | s_ch, s_first, s_after_dot, s_end_of_input        | request in
//   m_      | m_token_kind, m_type_code, m_value, m_error_code, | result out
//           | m_promotion, m_char_consumed                       |
//   cfg_    | cfg_wr_en, cfg_index, cfg_data                     | register write
//
// One character request per cycle while s_ready is high; a taken request is registered, then the
// step logic between the request register and the result register produces its result.
// Reset (aresetn low, synchronous) clears the scan state and loads the default masks.
// A request that ends a constant waits in the request register while an untaken
// result is still held; requests that give no result pass regardless.
`default_nettype none
module c_numeric_constant_scanner_top #(
    parameter int MAX_CHARS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_first,
    input  wire logic        s_after_dot,
    input  wire logic        s_end_of_input,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_token_kind,
    output logic [2:0]       m_type_code,
    output logic [31:0]      m_value,
    output logic [1:0]       m_error_code,
    output logic [1:0]       m_promotion,
    output logic             m_char_consumed,

    input  wire logic                          cfg_wr_en,
    input  wire logic [cns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic       in_vld_reg;
    logic [7:0] in_ch_reg;
    logic       in_first_reg;
    logic       in_adot_reg;
    logic       in_eoi_reg;

    cns_pkg::scan_state_t scan_reg;
    cns_pkg::scan_state_t scan_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    cns_pkg::masks_t      masks_reg;

    logic                 has_result;
    cns_pkg::result_t     step_res;
    cns_pkg::result_t     out_reg;
    logic                 out_vld_reg;

    logic                 proceed;

    assign proceed = in_vld_reg && (!has_result || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_ch_reg    <= s_ch;
            in_first_reg <= s_first;
            in_adot_reg  <= s_after_dot;
            in_eoi_reg   <= s_end_of_input;
        end
    end

    cns_step #(
        .MAX_CHARS (MAX_CHARS),
        .CNT_W     (CNT_W)
    ) u_step (
        .cur_st       (scan_reg),
        .cur_cnt      (cnt_reg),
        .masks        (masks_reg),
        .ch           (in_ch_reg),
        .first        (in_first_reg),
        .after_dot    (in_adot_reg),
        .end_of_input (in_eoi_reg),
        .nxt_st       (scan_next),
        .nxt_cnt      (cnt_next),
        .has_result   (has_result),
        .result       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= cns_pkg::SCAN_CLEAR;
            cnt_reg  <= '0;
        end else if (proceed) begin
            scan_reg <= scan_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proceed && has_result) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && has_result) begin
            out_reg <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            masks_reg.si_mask <= cns_pkg::SIMASK;
            masks_reg.ui_mask <= cns_pkg::UIMASK;
            masks_reg.sl_mask <= cns_pkg::SLMASK;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cns_pkg::CFG_SI_MASK: masks_reg.si_mask <= cfg_data;
                cns_pkg::CFG_UI_MASK: masks_reg.ui_mask <= cfg_data;
                cns_pkg::CFG_SL_MASK: masks_reg.sl_mask <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_token_kind    = out_reg.token_kind;
    assign m_type_code     = out_reg.type_code;
    assign m_value         = out_reg.value;
    assign m_error_code    = out_reg.error_code;
    assign m_promotion     = out_reg.promotion;
    assign m_char_consumed = out_reg.char_consumed;

endmodule
`default_nettype wire

@@ sv/cns_finish.sv @@
// Classification of a finished constant: kind, type, value, error, promotion.
`default_nettype none
module cns_finish (
    input  var cns_pkg::scan_state_t st,
    input  var cns_pkg::masks_t      masks,
    output cns_pkg::result_t         res
);

    logic        ftext;
    logic [31:0] n;
    logic        hit_si;
    logic        hit_ui;
    logic        hit_sl;

    assign ftext  = st.dot_seen | st.exp_seen;
    assign n      = st.acc;
    assign hit_si = |(n & masks.si_mask);
    assign hit_ui = |(n & masks.ui_mask);
    assign hit_sl = |(n & masks.sl_mask);

    always_comb begin
        res.token_kind    = cns_pkg::KIND_INT;
        res.type_code     = cns_pkg::TY_INT;
        res.error_code    = cns_pkg::ERR_NONE;
        res.promotion     = cns_pkg::PROMO_NONE;
        res.char_consumed = 1'b0;

        if (st.too_long) begin
            res.error_code = cns_pkg::ERR_TOO_LONG;
        end else if (ftext || st.flt_sfx != 2'd0) begin
            if (st.uns_sfx != 2'd0 || ({1'b0, st.flt_sfx} + {1'b0, st.long_sfx}) > 3'd1) begin
                res.error_code = cns_pkg::ERR_FLT_SUFX;
            end else begin
                res.token_kind = cns_pkg::KIND_FLOAT;
                res.type_code  = (st.flt_sfx != 2'd0)  ? cns_pkg::TY_FLOAT :
                                 (st.long_sfx != 2'd0) ? cns_pkg::TY_LDBL  :
                                                         cns_pkg::TY_DOUBLE;
            end
        end else if (st.uns_sfx > 2'd1 || st.long_sfx > 2'd1) begin
            res.error_code = cns_pkg::ERR_INT_SUFX;
        end else if (st.long_sfx != 2'd0) begin
            res.token_kind = cns_pkg::KIND_LONG;
            res.type_code  = (st.uns_sfx != 2'd0 || hit_sl) ? cns_pkg::TY_ULONG
                                                             : cns_pkg::TY_LONG;
        end else if (st.uns_sfx != 2'd0) begin
            res.type_code = cns_pkg::TY_UINT;
            if (hit_ui) begin
                res.token_kind = cns_pkg::KIND_LONG;
                res.type_code  = cns_pkg::TY_ULONG;
                res.promotion  = cns_pkg::PROMO_ULONG;
            end
        end else if (st.base == cns_pkg::BASE_DEC && hit_si) begin
            // decimal skips unsigned int
            res.token_kind = cns_pkg::KIND_LONG;
            res.type_code  = cns_pkg::TY_LONG;
            res.promotion  = cns_pkg::PROMO_LONG;
            if (hit_sl) begin
                res.type_code = cns_pkg::TY_ULONG;
                res.promotion = cns_pkg::PROMO_ULONG;
            end
        end else if (hit_si) begin
            res.type_code = cns_pkg::TY_UINT;
            if (hit_ui) begin
                res.token_kind = cns_pkg::KIND_LONG;
                res.type_code  = cns_pkg::TY_LONG;
                res.promotion  = cns_pkg::PROMO_LONG;
                if (hit_sl) begin
                    res.type_code = cns_pkg::TY_ULONG;
                    res.promotion = cns_pkg::PROMO_ULONG;
                end
            end
        end

        res.value = (ftext || res.token_kind == cns_pkg::KIND_FLOAT) ? 32'd0 : n;
    end

endmodule
`default_nettype wire

@@ sv/cns_step.sv @@
// Next-state logic of the scanner for one character request.
`default_nettype none
module cns_step #(
    parameter int MAX_CHARS = 32,
    parameter int CNT_W     = 6
) (
    input  var cns_pkg::scan_state_t cur_st,
    input  wire logic [CNT_W-1:0]    cur_cnt,
    input  var cns_pkg::masks_t      masks,
    input  wire logic [7:0]          ch,
    input  wire logic                first,
    input  wire logic                after_dot,
    input  wire logic                end_of_input,
    output cns_pkg::scan_state_t     nxt_st,
    output logic [CNT_W-1:0]         nxt_cnt,
    output logic                     has_result,
    output cns_pkg::result_t         result
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

    cns_pkg::scan_state_t pre_st;
    logic [CNT_W-1:0]     pre_cnt;
    logic                 do_body;
    logic                 do_sfx_only;

    cns_pkg::scan_state_t body_st;
    logic [CNT_W-1:0]     body_cnt;
    logic                 body_ok;

    // state the step works from, plus which path it takes
    always_comb begin
        pre_st      = cur_st;
        pre_cnt     = cur_cnt;
        do_body     = 1'b0;
        do_sfx_only = 1'b0;
        if (end_of_input) begin
            if (cur_st.phase == cns_pkg::PH_ZERO) begin
                // lone 0 is an octal digit
                pre_st.base = cns_pkg::BASE_OCT;
                pre_st.acc  = {cur_st.acc[28:0], 3'b000};
                if (cur_cnt < CNT_MAX) pre_cnt = cur_cnt + CNT_W'(1);
                else                   pre_st.too_long = 1'b1;
            end
        end else if (first) begin
            pre_st  = cns_pkg::SCAN_CLEAR;
            pre_cnt = '0;
            if (after_dot) begin
                pre_st.dot_seen = 1'b1;
                pre_cnt         = CNT_W'(1);
                do_body         = 1'b1;
            end else if (ch != "0") begin
                do_body = 1'b1;
            end
        end else begin
            case (cur_st.phase)
                cns_pkg::PH_ZERO: begin
                    if (ch != "x" && ch != "X") begin
                        pre_st.base = cns_pkg::BASE_OCT;
                        pre_st.acc  = {cur_st.acc[28:0], 3'b000};
                        if (cur_cnt < CNT_MAX) pre_cnt = cur_cnt + CNT_W'(1);
                        else                   pre_st.too_long = 1'b1;
                        do_body = 1'b1;
                    end
                end
                cns_pkg::PH_BODY:   do_body     = 1'b1;
                cns_pkg::PH_SUFFIX: do_sfx_only = 1'b1;
                default:            ;
            endcase
        end
    end

    // one body character applied to pre_st
    always_comb begin
        logic        hex;
        logic        is_num;
        logic [3:0]  dig;
        logic [31:0] acc_sh;
        hex      = (pre_st.base == cns_pkg::BASE_HEX);
        body_st  = pre_st;
        body_cnt = pre_cnt;
        body_ok  = 1'b1;
        is_num   = 1'b0;
        dig      = ch[3:0];
        if (!hex && ch == ".") begin
            if (pre_st.dot_seen) body_ok = 1'b0;
            else                 body_st.dot_seen = 1'b1;
        end else if (ch == "+" || ch == "-") begin
            if (!pre_st.sign_ok) body_ok = 1'b0;
            else                 body_st.sign_ok = 1'b0;
        end else if (!hex && (ch == "e" || ch == "E")) begin
            if (pre_st.exp_seen) begin
                body_ok = 1'b0;
            end else begin
                body_st.exp_seen = 1'b1;
                body_st.sign_ok  = 1'b1;
            end
        end else if (ch inside {["0":"9"]}) begin
            body_st.sign_ok = 1'b0;
            is_num          = 1'b1;
        end else if (hex && (ch inside {["a":"f"], ["A":"F"]})) begin
            is_num = 1'b1;
            dig    = ch[3:0] + 4'd9;
        end else begin
            body_ok = 1'b0;
        end

        case (pre_st.base)
            cns_pkg::BASE_HEX: acc_sh = {pre_st.acc[27:0], 4'b0000};
            cns_pkg::BASE_OCT: acc_sh = {pre_st.acc[28:0], 3'b000};
            default:           acc_sh = {pre_st.acc[28:0], 3'b000} + {pre_st.acc[30:0], 1'b0};
        endcase
        if (is_num) body_st.acc = acc_sh + {28'd0, dig};

        if (body_ok) begin
            if (pre_cnt < CNT_MAX) body_cnt = pre_cnt + CNT_W'(1);
            else                   body_st.too_long = 1'b1;
        end
    end

    // pick the outcome
    always_comb begin
        logic sfx_path;
        logic [CNT_W-1:0] c1;
        nxt_st     = cur_st;
        nxt_cnt    = cur_cnt;
        has_result = 1'b0;
        c1         = cur_cnt;
        sfx_path   = do_sfx_only || (do_body && !body_ok);

        if (end_of_input) begin
            has_result = (cur_st.phase != cns_pkg::PH_IDLE);
        end else if (first && !after_dot && ch == "0") begin
            nxt_st       = cns_pkg::SCAN_CLEAR;
            nxt_st.phase = cns_pkg::PH_ZERO;
            nxt_cnt      = '0;
        end else if (!first && cur_st.phase == cns_pkg::PH_ZERO && (ch == "x" || ch == "X")) begin
            // the 0x prefix counts as two characters
            nxt_st.base  = cns_pkg::BASE_HEX;
            nxt_st.phase = cns_pkg::PH_BODY;
            c1           = cur_cnt;
            if (c1 < CNT_MAX) c1 = c1 + CNT_W'(1);
            else              nxt_st.too_long = 1'b1;
            if (c1 < CNT_MAX) c1 = c1 + CNT_W'(1);
            else              nxt_st.too_long = 1'b1;
            nxt_cnt = c1;
        end else if (do_body && body_ok) begin
            nxt_st       = body_st;
            nxt_st.phase = cns_pkg::PH_BODY;
            nxt_cnt      = body_cnt;
        end else if (sfx_path) begin
            nxt_st       = pre_st;
            nxt_st.phase = cns_pkg::PH_SUFFIX;
            nxt_cnt      = pre_cnt;
            if (ch == "l" || ch == "L") begin
                nxt_st.long_sfx = cns_pkg::sat_inc(pre_st.long_sfx);
            end else if (ch == "u" || ch == "U") begin
                nxt_st.uns_sfx = cns_pkg::sat_inc(pre_st.uns_sfx);
            end else if (ch == "f" || ch == "F") begin
                nxt_st.flt_sfx = cns_pkg::sat_inc(pre_st.flt_sfx);
            end else begin
                has_result = 1'b1;
            end
        end

        if (has_result) begin
            nxt_st  = cns_pkg::SCAN_CLEAR;
            nxt_cnt = '0;
        end
    end

    cns_finish u_finish (
        .st    (pre_st),
        .masks (masks),
        .res   (result)
    );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the C numeric constant scanner: random lexemes, mask settings, stalls.
module testbench;

    localparam int SCAN_MAX    = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 190;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       after_dot;
        logic       eoi;
    } char_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = 8'd0;
    logic        s_first = 1'b0;
    logic        s_after_dot = 1'b0;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_token_kind;
    logic [2:0]  m_type_code;
    logic [31:0] m_value;
    logic [1:0]  m_error_code;
    logic [1:0]  m_promotion;
    logic        m_char_consumed;
    logic                          cfg_wr_en = 1'b0;
    logic [cns_pkg::CFG_IDX_W-1:0] cfg_index = cns_pkg::CFG_SI_MASK;
    logic [31:0]                   cfg_data = 32'd0;

    c_numeric_constant_scanner_top #(.MAX_CHARS(SCAN_MAX)) dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    char_req_t        char_queue[$];
    cns_pkg::result_t token_queue[$];

    int gap_pct = 33;
    int stall_pct = 33;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int queued_items = 0;
    int chars_taken = 0;
    int tokens_seen = 0;
    int mask_settings = 1;
    int cycle_count = 0;

    // scanner state as predicted
    logic [31:0]     mask_si, mask_ui, mask_sl;
    cns_pkg::phase_t sc_phase;
    cns_pkg::base_t  sc_base;
    logic            sc_dot, sc_exp, sc_sign_ok, sc_too_long;
    logic [31:0]     sc_acc;
    int              sc_count;
    logic [1:0]      sc_long, sc_uns, sc_flt;

    function automatic void clear_scan_state();
        sc_phase    = cns_pkg::PH_IDLE;
        sc_base     = cns_pkg::BASE_DEC;
        sc_dot      = 1'b0;
        sc_exp      = 1'b0;
        sc_sign_ok  = 1'b0;
        sc_acc      = 32'd0;
        sc_count    = 0;
        sc_too_long = 1'b0;
        sc_long     = 2'd0;
        sc_uns      = 2'd0;
        sc_flt      = 2'd0;
    endfunction

    function automatic void bump_count();
        if (sc_count < SCAN_MAX)
            sc_count++;
        else
            sc_too_long = 1'b1;
    endfunction

    function automatic void add_digit(logic [7:0] d);
        logic [31:0] mul;
        mul = (sc_base == cns_pkg::BASE_HEX) ? 32'd16 :
              (sc_base == cns_pkg::BASE_OCT) ? 32'd8 : 32'd10;
        sc_acc = sc_acc * mul + {24'd0, d};
    endfunction

    function automatic logic [1:0] bump_sfx(logic [1:0] v);
        return (v == 2'd2) ? v : v + 2'd1;
    endfunction

    // returns 1 when c ends the body
    function automatic bit body_reject(logic [7:0] c);
        bit hex;
        hex = (sc_base == cns_pkg::BASE_HEX);
        if (!hex && c == ".") begin
            if (sc_dot)
                return 1'b1;
            sc_dot = 1'b1;
        end else if (c == "+" || c == "-") begin
            if (!sc_sign_ok)
                return 1'b1;
            sc_sign_ok = 1'b0;
        end else if (!hex && (c == "e" || c == "E")) begin
            if (sc_exp)
                return 1'b1;
            sc_exp = 1'b1;
            sc_sign_ok = 1'b1;
        end else if (c >= "0" && c <= "9") begin
            sc_sign_ok = 1'b0;
            add_digit(c - "0");
        end else if (hex && c >= "a" && c <= "f") begin
            add_digit(c - "a" + 8'd10);
        end else if (hex && c >= "A" && c <= "F") begin
            add_digit(c - "A" + 8'd10);
        end else begin
            return 1'b1;
        end
        bump_count();
        return 1'b0;
    endfunction

    function automatic void close_constant();
        cns_pkg::result_t r;
        logic    ftext;
        logic [31:0] n;
        ftext = sc_dot || sc_exp;
        n = sc_acc;
        r.token_kind = cns_pkg::KIND_INT;
        r.type_code = cns_pkg::TY_INT;
        r.error_code = cns_pkg::ERR_NONE;
        r.promotion = cns_pkg::PROMO_NONE;
        r.char_consumed = 1'b0;
        if (sc_too_long) begin
            r.error_code = cns_pkg::ERR_TOO_LONG;
        end else if (ftext || sc_flt != 2'd0) begin
            if (sc_uns != 2'd0 || ({1'b0, sc_flt} + {1'b0, sc_long}) > 3'd1) begin
                r.error_code = cns_pkg::ERR_FLT_SUFX;
            end else begin
                r.token_kind = cns_pkg::KIND_FLOAT;
                r.type_code = (sc_flt != 2'd0) ? cns_pkg::TY_FLOAT :
                              (sc_long != 2'd0) ? cns_pkg::TY_LDBL : cns_pkg::TY_DOUBLE;
            end
        end else if (sc_uns > 2'd1 || sc_long > 2'd1) begin
            r.error_code = cns_pkg::ERR_INT_SUFX;
        end else if (sc_long != 2'd0) begin
            r.token_kind = cns_pkg::KIND_LONG;
            r.type_code = (sc_uns != 2'd0 || (n & mask_sl) != 0) ? cns_pkg::TY_ULONG
                                                                : cns_pkg::TY_LONG;
        end else if (sc_uns != 2'd0) begin
            r.type_code = cns_pkg::TY_UINT;
            if ((n & mask_ui) != 0) begin
                r.token_kind = cns_pkg::KIND_LONG;
                r.type_code = cns_pkg::TY_ULONG;
                r.promotion = cns_pkg::PROMO_ULONG;
            end
        end else if (sc_base == cns_pkg::BASE_DEC && (n & mask_si) != 0) begin
            // decimal skips unsigned int and goes straight to long
            r.token_kind = cns_pkg::KIND_LONG;
            r.type_code = cns_pkg::TY_LONG;
            r.promotion = cns_pkg::PROMO_LONG;
            if ((n & mask_sl) != 0) begin
                r.type_code = cns_pkg::TY_ULONG;
                r.promotion = cns_pkg::PROMO_ULONG;
            end
        end else if ((n & mask_si) != 0) begin
            r.type_code = cns_pkg::TY_UINT;
            if ((n & mask_ui) != 0) begin
                r.token_kind = cns_pkg::KIND_LONG;
                r.type_code = cns_pkg::TY_LONG;
                r.promotion = cns_pkg::PROMO_LONG;
                if ((n & mask_sl) != 0) begin
                    r.type_code = cns_pkg::TY_ULONG;
                    r.promotion = cns_pkg::PROMO_ULONG;
                end
            end
        end
        r.value = (ftext || r.token_kind == cns_pkg::KIND_FLOAT) ? 32'd0 : n;
        token_queue.push_back(r);
        clear_scan_state();
    endfunction

    function automatic void suffix_step(logic [7:0] c);
        if (c == "l" || c == "L")
            sc_long = bump_sfx(sc_long);
        else if (c == "u" || c == "U")
            sc_uns = bump_sfx(sc_uns);
        else if (c == "f" || c == "F")
            sc_flt = bump_sfx(sc_flt);
        else
            close_constant();
    endfunction

    function automatic void body_or_suffix(logic [7:0] c);
        sc_phase = cns_pkg::PH_BODY;
        if (body_reject(c)) begin
            sc_phase = cns_pkg::PH_SUFFIX;
            suffix_step(c);
        end
    endfunction

    // advances the predicted scanner by one accepted request
    function automatic void scan_char(logic [7:0] c, logic first, logic adot, logic eoi);
        if (eoi) begin
            if (sc_phase == cns_pkg::PH_IDLE)
                return;
            if (sc_phase == cns_pkg::PH_ZERO) begin
                sc_base = cns_pkg::BASE_OCT;
                void'(body_reject("0"));
            end
            close_constant();
            return;
        end
        if (first) begin
            clear_scan_state();
            if (adot) begin
                sc_dot = 1'b1;
                bump_count();
            end else if (c == "0") begin
                sc_phase = cns_pkg::PH_ZERO;
                return;
            end
            body_or_suffix(c);
            return;
        end
        case (sc_phase)
            cns_pkg::PH_ZERO: begin
                if (c == "x" || c == "X") begin
                    sc_base = cns_pkg::BASE_HEX;
                    bump_count();
                    bump_count();
                    sc_phase = cns_pkg::PH_BODY;
                end else begin
                    sc_base = cns_pkg::BASE_OCT;
                    void'(body_reject("0"));
                    body_or_suffix(c);
                end
            end
            cns_pkg::PH_BODY:   body_or_suffix(c);
            cns_pkg::PH_SUFFIX: suffix_step(c);
            default: ;
        endcase
    endfunction

    // request driver
    always @(posedge aclk) begin : drv_proc
        char_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_char(s_ch, s_first, s_after_dot, s_end_of_input);
                chars_taken++;
            end
            if (!s_valid || s_ready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = char_queue.pop_front();
                    s_valid <= 1'b1;
                    s_ch <= nxt.ch;
                    s_first <= nxt.first;
                    s_after_dot <= nxt.after_dot;
                    s_end_of_input <= nxt.eoi;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin : mon_proc
        cns_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                tokens_seen++;
                if (token_queue.size() == 0) begin
                    $error("result with nothing outstanding: value %0h", m_value);
                    mismatches++;
                end else begin
                    want = token_queue.pop_front();
                    check_field("token_kind", 32'(want.token_kind), 32'(m_token_kind));
                    check_field("type_code", 32'(want.type_code), 32'(m_type_code));
                    check_field("value", want.value, m_value);
                    check_field("error_code", 32'(want.error_code), 32'(m_error_code));
                    check_field("promotion", 32'(want.promotion), 32'(m_promotion));
                    check_field("char_consumed", 32'(want.char_consumed),
                                32'(m_char_consumed));
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, token_queue.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic void queue_char(logic [7:0] c, bit f, bit ad, bit e);
        char_queue.push_back('{c, f, ad, e});
        queued_items++;
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // one lexeme: body in a random base, suffixes, then some way of ending it
    task automatic gen_constant();
        int len, term;
        logic [7:0] t;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10);
        case ($urandom_range(0, 3))
            0: begin
                queue_char(pick("123456789"), 1, 0, 0);
                repeat (len) queue_char(pick("0123456789"), 0, 0, 0);
            end
            1: begin
                queue_char("0", 1, 0, 0);
                repeat (len - 1) queue_char(pick("0123456789"), 0, 0, 0);
            end
            2: begin
                queue_char("0", 1, 0, 0);
                queue_char(pick("xX"), 0, 0, 0);
                if (len <= 10)
                    len = $urandom_range(1, 8);
                repeat (len) queue_char(pick("0123456789abcdefABCDEF"), 0, 0, 0);
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    queue_char(pick("0123456789"), 1, 1, 0);
                end else begin
                    queue_char(pick("123456789"), 1, 0, 0);
                    queue_char(pick(".eE"), 0, 0, 0);
                end
                repeat (len) queue_char(pick("0123456789012345.eE+-"), 0, 0, 0);
            end
        endcase
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) queue_char(pick("lLuUfF"), 0, 0, 0);
        term = $urandom_range(0, 9);
        if (term <= 5) begin
            t = (term == 5) ? 8'($urandom_range(0, 255)) : pick(" ,;)]x\t");
            queue_char(t, 0, 0, 0);
            // terminator offered again, as the caller would after a result
            if ($urandom_range(0, 2) == 0)
                char_queue.push_back('{t, 1'b0, 1'b0, 1'b0});
        end else if (term <= 7) begin
            queue_char(8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)), 1);
        end
        // otherwise the next lexeme's first request cuts this one off
    endtask

    task automatic fill_random(int n);
        int start;
        char_req_t junk;
        start = queued_items;
        while (queued_items - start < n) begin
            if ($urandom_range(0, 9) < 7) begin
                gen_constant();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    junk.ch = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                    : pick("0123456789.eE+-xXlLuUfFabcdef ");
                    junk.first = ($urandom_range(0, 2) == 0);
                    junk.after_dot = 1'($urandom_range(0, 1));
                    junk.eoi = ($urandom_range(0, 6) == 0);
                    char_queue.push_back(junk);
                    if (junk.first || junk.eoi)
                        queued_items++;
                end
            end
        end
        // leave the scanner idle before any register write
        queue_char(8'h00, 0, 0, 1);
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (char_queue.size() != 0 || s_valid || token_queue.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_masks(logic [31:0] si, logic [31:0] ui, logic [31:0] sl);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= cns_pkg::CFG_SI_MASK;
        cfg_data <= si;
        @(posedge aclk);
        cfg_index <= cns_pkg::CFG_UI_MASK;
        cfg_data <= ui;
        @(posedge aclk);
        cfg_index <= cns_pkg::CFG_SL_MASK;
        cfg_data <= sl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mask_si = si;
        mask_ui = ui;
        mask_sl = sl;
        mask_settings++;
        @(negedge aclk);
    endtask

    initial begin
        mask_si = cns_pkg::SIMASK;
        mask_ui = cns_pkg::UIMASK;
        mask_sl = cns_pkg::SLMASK;
        clear_scan_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: lone zero, hex with long suffix, fraction with exponent and
        // float suffix, doubled unsigned suffix, restart mid-constant, idle noise
        queue_char(8'hFF, 0, 0, 0);
        queue_char(8'hFF, 0, 1, 1);
        queue_char("0", 1, 0, 0);
        queue_char(8'h00, 0, 0, 1);
        queue_char("0", 1, 0, 0);
        queue_char("x", 0, 0, 0);
        queue_char("f", 0, 0, 0);
        queue_char("L", 0, 0, 0);
        queue_char(" ", 0, 0, 0);
        queue_char("5", 1, 1, 0);
        queue_char("e", 0, 0, 0);
        queue_char("-", 0, 0, 0);
        queue_char("3", 0, 0, 0);
        queue_char("f", 0, 0, 0);
        queue_char(";", 0, 0, 0);
        queue_char("9", 1, 0, 0);
        queue_char("u", 0, 0, 0);
        queue_char("u", 0, 0, 0);
        queue_char(8'h00, 0, 0, 0);
        queue_char("1", 1, 0, 0);
        queue_char("2", 1, 0, 0);
        queue_char(8'h00, 0, 0, 1);
        fill_random(PHASE_ITEMS);
        wait_drain();

        set_masks(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        fill_random(PHASE_ITEMS);
        wait_drain();

        // receiver holds off long enough for the input side to back up
        set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        fill_random(PHASE_ITEMS);
        wait_drain();

        gap_pct = 0;
        stall_pct = 0;
        set_masks($urandom(), $urandom(), $urandom());
        fill_random(PHASE_ITEMS);
        wait_drain();

        gap_pct = 33;
        stall_pct = 33;
        set_masks(cns_pkg::SIMASK, cns_pkg::UIMASK, cns_pkg::SLMASK);
        fill_random(PHASE_ITEMS);
        wait_drain();
        repeat (8) @(negedge aclk);

        $display("Scanned %0d requests, %0d tokens compared under %0d overflow-mask settings.",
                 chars_taken, tokens_seen, mask_settings);
        $display("Bases, float forms, suffix mixes, overlong text and restarts were exercised.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
